/* rtl/rau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, error codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FieldBits = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DIVZERO = 2'd1,
    ERR_SUBZERO = 2'd2
  } err_e;

  // datapath steps driven by the controller
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,     // capture operands
    CMD_MUL1,     // product set 1
    CMD_MUL2,     // product set 2
    CMD_FINISH,   // form add/mul/div result
    CMD_EUC_INIT, // x=ad, y=bd
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_EUC_NEXT, // x=y, y=rem
    CMD_L_START,  // l = |ad*bd| / g
    CMD_LA_START, // l / ad
    CMD_LB_START, // l / bd
    CMD_SUB_FIN,
    CMD_ERR
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_FINISH,
    ST_EUC_CHECK,
    ST_EUC_DIV,
    ST_L_DIV,
    ST_LA_DIV,
    ST_LB_DIV,
    ST_SUB_MUL,
    ST_SUB_FIN,
    ST_ERR,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] div_sel; // 0 euclid, 1 lcm, 2 l/ad, 3 l/bd
  } ctl_t;

  typedef struct packed {
    op_e  op;
    logic ad_zero;
    logic bd_zero;
    logic bn_zero;
    logic y_zero;
    logic div_done;
  } sts_t;

endpackage

/* rtl/rau_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Walks each word through products, the Euclid loop and the divides.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);

  rau_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctl_o.cmd      = rau_pkg::CMD_IDLE;
    ctl_o.div_sel  = 2'd0;
    busy_o         = 1'b1;
    done_o         = 1'b0;
    case (state_q)
      rau_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.cmd = rau_pkg::CMD_LOAD;
          state_d   = rau_pkg::ST_MUL1;
        end
      end
      rau_pkg::ST_MUL1: begin
        ctl_o.cmd = rau_pkg::CMD_MUL1;
        state_d   = rau_pkg::ST_MUL2;
        if (sts_i.op == rau_pkg::OP_SUB) begin
          if (sts_i.ad_zero || sts_i.bd_zero) begin
            state_d = rau_pkg::ST_ERR;
          end else begin
            ctl_o.cmd = rau_pkg::CMD_EUC_INIT;
            state_d   = rau_pkg::ST_EUC_CHECK;
          end
        end else if (sts_i.op == rau_pkg::OP_DIV && sts_i.bn_zero) begin
          state_d = rau_pkg::ST_ERR;
        end
      end
      rau_pkg::ST_MUL2: begin
        ctl_o.cmd = rau_pkg::CMD_MUL2;
        state_d   = rau_pkg::ST_FINISH;
      end
      rau_pkg::ST_FINISH: begin
        ctl_o.cmd = rau_pkg::CMD_FINISH;
        state_d   = rau_pkg::ST_DONE;
      end
      rau_pkg::ST_EUC_CHECK: begin
        if (sts_i.y_zero) begin
          // x holds g; load the |ad*bd| product into the divider
          ctl_o.cmd     = rau_pkg::CMD_L_START;
          ctl_o.div_sel = 2'd1;
          state_d       = rau_pkg::ST_L_DIV;
        end else begin
          ctl_o.cmd = rau_pkg::CMD_DIV_START;
          state_d   = rau_pkg::ST_EUC_DIV;
        end
      end
      rau_pkg::ST_EUC_DIV: begin
        ctl_o.cmd = rau_pkg::CMD_DIV_STEP;
        if (sts_i.div_done) begin
          ctl_o.cmd = rau_pkg::CMD_EUC_NEXT;
          state_d   = rau_pkg::ST_EUC_CHECK;
        end
      end
      rau_pkg::ST_L_DIV: begin
        ctl_o.cmd = rau_pkg::CMD_DIV_STEP;
        if (sts_i.div_done) begin
          ctl_o.cmd     = rau_pkg::CMD_LA_START;
          ctl_o.div_sel = 2'd2;
          state_d       = rau_pkg::ST_LA_DIV;
        end
      end
      rau_pkg::ST_LA_DIV: begin
        ctl_o.cmd = rau_pkg::CMD_DIV_STEP;
        if (sts_i.div_done) begin
          ctl_o.cmd     = rau_pkg::CMD_LB_START;
          ctl_o.div_sel = 2'd3;
          state_d       = rau_pkg::ST_LB_DIV;
        end
      end
      rau_pkg::ST_LB_DIV: begin
        ctl_o.cmd = rau_pkg::CMD_DIV_STEP;
        if (sts_i.div_done) begin
          ctl_o.cmd = rau_pkg::CMD_MUL2;
          state_d   = rau_pkg::ST_SUB_FIN;
        end
      end
      rau_pkg::ST_SUB_FIN: begin
        ctl_o.cmd = rau_pkg::CMD_SUB_FIN;
        state_d   = rau_pkg::ST_DONE;
      end
      rau_pkg::ST_ERR: begin
        ctl_o.cmd = rau_pkg::CMD_ERR;
        state_d   = rau_pkg::ST_DONE;
      end
      rau_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = rau_pkg::ST_IDLE;
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/rau_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp: datapath for the rational arithmetic unit
// Operand registers, one multiplier pair per step and a radix-2 divider.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int unsigned WordBits = rau_pkg::WordBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    mode_i,
  input  logic [31:0]   a_num_i,
  input  logic [31:0]   a_den_i,
  input  logic [31:0]   b_num_i,
  input  logic [31:0]   b_den_i,
  input  rau_pkg::ctl_t ctl_i,
  output rau_pkg::sts_t sts_o,
  output logic [31:0]   res_num_o,
  output logic [31:0]   res_den_o,
  output logic [1:0]    error_o
);

  localparam int unsigned CntBits = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;

  rau_pkg::op_e op_q;
  word_t an_q, ad_q, bn_q, bd_q;
  word_t p0_q, p1_q, p2_q;
  word_t x_q, y_q, l_q, qa_q;
  word_t rn_q, rd_q;
  logic [1:0] err_q;

  // divider: unsigned magnitudes, sign fixed on completion
  word_t dq_q, dr_q, dm_q;
  logic dqneg_q, drneg_q;
  logic [CntBits-1:0] dcnt_q;
  logic dbusy_q;

  word_t dvd_sel, dvs_sel;
  word_t rem_try, dr_shift;
  word_t q_sgn, r_sgn;
  logic div_last;

  function automatic word_t mag_f(word_t v);
    return v[WordBits-1] ? word_t'(-v) : v;
  endfunction

  function automatic word_t ext_f(logic [31:0] v);
    logic [63:0] s;
    s = {{32{v[31]}}, v};
    return s[WordBits-1:0];
  endfunction

  function automatic logic [31:0] fld_f(word_t v);
    logic [63:0] s;
    s = 64'(signed'(v));
    return s[31:0];
  endfunction

  always_comb begin
    case (ctl_i.div_sel)
      2'd0:    begin dvd_sel = x_q;             dvs_sel = y_q;  end
      2'd1:    begin dvd_sel = mag_f(p1_q);     dvs_sel = x_q;  end
      // l is still in the divider output here
      2'd2:    begin dvd_sel = q_sgn;           dvs_sel = ad_q; end
      default: begin dvd_sel = l_q;             dvs_sel = bd_q; end
    endcase
  end

  assign dr_shift = {dr_q[WordBits-2:0], dq_q[WordBits-1]};
  assign rem_try  = dr_shift - dm_q;
  assign div_last = dbusy_q && (dcnt_q == CntBits'(1));
  assign q_sgn    = dqneg_q ? word_t'(-dq_q) : dq_q;
  assign r_sgn    = drneg_q ? word_t'(-dr_q) : dr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (ctl_i.cmd == rau_pkg::CMD_DIV_START || ctl_i.cmd == rau_pkg::CMD_L_START ||
                 ctl_i.cmd == rau_pkg::CMD_LA_START || ctl_i.cmd == rau_pkg::CMD_LB_START) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= CntBits'(WordBits);
    end else if (dbusy_q) begin
      dcnt_q  <= dcnt_q - CntBits'(1);
      dbusy_q <= !div_last;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      rau_pkg::CMD_LOAD: begin
        op_q <= rau_pkg::op_e'(mode_i);
        an_q <= ext_f(a_num_i);
        ad_q <= ext_f(a_den_i);
        bn_q <= ext_f(b_num_i);
        bd_q <= ext_f(b_den_i);
      end
      rau_pkg::CMD_MUL1: begin
        // add/mul: an*bd or an*bn; div: an*bd
        p0_q <= (op_q == rau_pkg::OP_MUL) ? word_t'(an_q * bn_q) : word_t'(an_q * bd_q);
        p1_q <= (op_q == rau_pkg::OP_DIV) ? word_t'(ad_q * bn_q) : word_t'(ad_q * bd_q);
      end
      rau_pkg::CMD_MUL2: begin
        // add: ad*bn; sub: an*(l/ad) and bn*(l/bd)
        if (op_q == rau_pkg::OP_SUB) begin
          p0_q <= word_t'(an_q * qa_q);
          p2_q <= word_t'(bn_q * q_sgn);
        end else begin
          p2_q <= word_t'(ad_q * bn_q);
        end
      end
      rau_pkg::CMD_FINISH: begin
        err_q <= rau_pkg::ERR_NONE;
        case (op_q)
          rau_pkg::OP_ADD: begin
            rn_q <= p0_q + p2_q;
            rd_q <= p1_q;
          end
          rau_pkg::OP_DIV: begin
            rn_q <= p0_q;
            rd_q <= (p1_q == '0) ? word_t'(1) : p1_q;
          end
          default: begin
            rn_q <= p0_q;
            rd_q <= p1_q;
          end
        endcase
      end
      rau_pkg::CMD_EUC_INIT: begin
        x_q  <= ad_q;
        y_q  <= bd_q;
        p1_q <= word_t'(ad_q * bd_q);
      end
      rau_pkg::CMD_EUC_NEXT: begin
        x_q <= y_q;
        y_q <= r_sgn;
      end
      rau_pkg::CMD_SUB_FIN: begin
        err_q <= rau_pkg::ERR_NONE;
        rn_q  <= p0_q - p2_q;
        rd_q  <= l_q;
      end
      rau_pkg::CMD_ERR: begin
        rn_q  <= word_t'(1);
        rd_q  <= word_t'(1);
        err_q <= (op_q == rau_pkg::OP_DIV) ? rau_pkg::ERR_DIVZERO : rau_pkg::ERR_SUBZERO;
      end
      default: ;
    endcase
    if (ctl_i.cmd == rau_pkg::CMD_LA_START) begin
      l_q <= q_sgn;
    end
    if (ctl_i.cmd == rau_pkg::CMD_LB_START) begin
      qa_q <= q_sgn;
    end
    // divider load / iterate
    if (ctl_i.cmd == rau_pkg::CMD_DIV_START || ctl_i.cmd == rau_pkg::CMD_L_START ||
        ctl_i.cmd == rau_pkg::CMD_LA_START || ctl_i.cmd == rau_pkg::CMD_LB_START) begin
      dq_q    <= mag_f(dvd_sel);
      dm_q    <= mag_f(dvs_sel);
      dr_q    <= '0;
      dqneg_q <= dvd_sel[WordBits-1] ^ dvs_sel[WordBits-1];
      drneg_q <= dvd_sel[WordBits-1];
    end else if (dbusy_q) begin
      if (dr_shift >= dm_q && !(dr_q[WordBits-1])) begin
        dr_q <= rem_try;
        dq_q <= {dq_q[WordBits-2:0], 1'b1};
      end else if (dr_q[WordBits-1]) begin
        // shifted remainder overflowed the word: it is >= divisor
        dr_q <= rem_try;
        dq_q <= {dq_q[WordBits-2:0], 1'b1};
      end else begin
        dr_q <= dr_shift;
        dq_q <= {dq_q[WordBits-2:0], 1'b0};
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.ad_zero  = (ad_q == '0);
  assign sts_o.bd_zero  = (bd_q == '0);
  assign sts_o.bn_zero  = (bn_q == '0);
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.div_done = dbusy_q && !div_last ? 1'b0 : !dbusy_q;

  assign res_num_o = fld_f(rn_q);
  assign res_den_o = fld_f(rd_q);
  assign error_o   = err_q;

endmodule

/* rtl/rational_arithmetic_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: fraction add, subtract, multiply, divide
// Add, multiply and divide pass through the product and finish states before
// the strobe; a zero divisor or a zero denominator in subtract goes through the
// error state instead. Subtract runs Euclid on a shared radix-2 divider, one
// divide per remainder step, then three more divides.
// One word at a time; busy stays high through the strobe cycle. Reset returns
// the sequencer to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        done_o,
  output logic [31:0] res_num_o,
  output logic [31:0] res_den_o,
  output logic [1:0]  error_o
);

  rau_pkg::ctl_t ctl;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy),
    .done_o (done_o)
  );

  rau_dp #(.WordBits(WORD_BITS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .error_o  (error_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("strobe while idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe longer than one cycle");

  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o) else $error("result right after accept");

  a_err_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o != rau_pkg::ERR_NONE) |-> (res_num_o == 32'd1 && res_den_o == 32'd1))
    else $error("error result not 1/1");

endmodule

/* verif/rational_arithmetic_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker: result predictor and scoreboard
// Watches accepted commands, predicts the fraction and error code of each
// and compares every strobed word against the oldest prediction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  input  logic        done_i,
  input  logic [31:0] res_num_i,
  input  logic [31:0] res_den_i,
  input  logic [1:0]  error_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          accepted_o
);

  typedef struct packed {
    logic [31:0]   num;
    logic [31:0]   den;
    rau_pkg::err_e err;
  } frac_t;

  frac_t fracs_q[$];

  function automatic logic [31:0] abs_w(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] quot_w(logic [31:0] x, logic [31:0] y);
    logic [31:0] q;
    q = abs_w(x) / abs_w(y);
    return (x[31] != y[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] rem_w(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    r = abs_w(x) % abs_w(y);
    return x[31] ? -r : r;
  endfunction

  function automatic frac_t calc_frac(rau_pkg::op_e op, logic [31:0] an, logic [31:0] ad,
                                      logic [31:0] bn, logic [31:0] bd);
    frac_t f;
    logic [31:0] x, y, t, lcm;
    f = '{num: 32'd1, den: 32'd1, err: rau_pkg::ERR_NONE};
    case (op)
      rau_pkg::OP_ADD: begin
        f.num = an * bd + ad * bn;
        f.den = ad * bd;
      end
      rau_pkg::OP_SUB: begin
        if (ad == 0 || bd == 0) begin
          f.err = rau_pkg::ERR_SUBZERO;
        end else begin
          x = ad;
          y = bd;
          while (y != 0) begin
            t = y;
            y = rem_w(x, y);
            x = t;
          end
          lcm = quot_w(abs_w(ad * bd), x);
          f.num = an * quot_w(lcm, ad) - bn * quot_w(lcm, bd);
          f.den = lcm;
        end
      end
      rau_pkg::OP_MUL: begin
        f.num = an * bn;
        f.den = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          f.err = rau_pkg::ERR_DIVZERO;
        end else begin
          f.num = an * bd;
          f.den = ad * bn;
          if (f.den == 0) f.den = 32'd1;
        end
      end
    endcase
    return f;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch got %h want %h", $time, what, got, want);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    accepted_o = 0;
  end

  assign pending_o = fracs_q.size();

  always @(posedge clk_i) begin
    frac_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        fracs_q.push_back(calc_frac(rau_pkg::op_e'(mode_i), a_num_i, a_den_i, b_num_i,
                                    b_den_i));
        accepted_o++;
      end
      if (done_i) begin
        if (fracs_q.size() == 0) begin
          report("unexpected word", res_num_i, 32'd0);
        end else begin
          want = fracs_q.pop_front();
          if (res_num_i !== want.num) report("res_num", res_num_i, want.num);
          if (res_den_i !== want.den) report("res_den", res_den_i, want.den);
          if (error_i !== want.err) report("error", {30'd0, error_i}, {30'd0, want.err});
        end
      end
    end
  end

endmodule

/* verif/rational_arithmetic_unit_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_tb: fraction unit testbench
// Directed corner commands then random bursts of all four operations; the
// checker predicts and compares every word, a watchdog catches hangs.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top_tb;

  localparam int NumRandom = 430;
  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = '0;
  logic [31:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic        done_o;
  logic [31:0] res_num_o, res_den_o;
  logic [1:0]  error_o;
  int          fail_cnt, pending, accepted;
  int          idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  rational_arithmetic_unit_top u_top (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .a_num_i, .a_den_i, .b_num_i,
    .b_den_i, .done_o, .res_num_o, .res_den_o, .error_o
  );

  rational_arithmetic_unit_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .mode_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .done_i(done_o), .res_num_i(res_num_o), .res_den_i(res_den_o),
    .error_i(error_o), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .accepted_o(accepted)
  );

  // watchdog: cycles with neither a command nor a word accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("rational_arithmetic_unit_top_tb NOT OK");
      $finish;
    end
  end

  // mostly small operands keep Euclid short; some full-range words
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3:       return 32'd0;
      4:       return -$urandom_range(1, 300);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic send(rau_pkg::op_e op, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    start   <= 1'b1;
    mode_i  <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int burst;
    rau_pkg::op_e op;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // corners: extremes, zero divisor, zero denominators, wrapped common den
    for (int m = 0; m < 4; m++) begin
      send(rau_pkg::op_e'(m), 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send(rau_pkg::op_e'(m), 32'd3, 32'd0, 32'd0, 32'd5);
      send(rau_pkg::op_e'(m), 32'hffff_ffff, 32'h0001_0000, 32'd7, 32'h0001_0000);
      send(rau_pkg::op_e'(m), 32'd1, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
      send(rau_pkg::op_e'(m), 32'h8000_0000, 32'h8000_0000, 32'd2, 32'hffff_ffff);
    end
    send(rau_pkg::OP_DIV, 32'd5, 32'h0001_0000, 32'h0001_0000, 32'd3);
    send(rau_pkg::OP_SUB, 32'd1, 32'd6, 32'd1, 32'h0000_0000);
    send(rau_pkg::OP_SUB, 32'd1, -32'd12, 32'd5, 32'd18);
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        op = rau_pkg::op_e'($urandom_range(0, 3));
        send(op, pick_word(), pick_word(), pick_word(), pick_word());
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("rational_arithmetic_unit_top_tb OK");
    else $display("rational_arithmetic_unit_top_tb NOT OK");
    $finish;
  end

endmodule

/* rational_arithmetic_unit_top.f */
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit_top.sv
verif/rational_arithmetic_unit_checker.sv
verif/rational_arithmetic_unit_top_tb.sv
